@@ sv/owrtc_pkg.sv @@
// Package for the one-wire RTC/NVRAM device: bus phases, commands, state codes,
// the command bytes and the clock-register address window.
// No dependencies.
`default_nettype none
package owrtc_pkg;

    localparam int NVRAM_BYTES_DEF   = 512;
    localparam int SCRATCH_BYTES_DEF = 32;

    localparam logic [7:0]  ROM_SKIP     = 8'hCC;
    localparam logic [7:0]  MEM_WRITE_SP = 8'h0F;
    localparam logic [7:0]  MEM_COPY_SP  = 8'h55;
    localparam logic [7:0]  MEM_READ     = 8'hF0;
    localparam logic [15:0] CLK_FIRST    = 16'h0202;
    localparam logic [15:0] CLK_LAST     = 16'h0206;
    localparam logic [2:0]  CLK_TOP_SLOT = 3'd4;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_PULSE = 3'd2,
        CMD_RST1W = 3'd3,
        CMD_RST3W = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        PH_INACTIVE  = 4'd0,
        PH_ROM       = 4'd1,
        PH_CMD       = 4'd2,
        PH_ADDR_LO   = 4'd3,
        PH_ADDR_HI   = 4'd4,
        PH_COUNT     = 4'd5,
        PH_READ_MEM  = 4'd6,
        PH_WRITE_SP  = 4'd7,
        PH_COPY_DONE = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        OP_WRITE_SP = 2'd0,
        OP_COPY     = 2'd1,
        OP_READ_MEM = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_READ  = 2'd2,
        S_COPY  = 2'd3
    } t_state;

endpackage
`default_nettype wire

@@ sv/one_wire_rtc_nvram_device.sv @@
// Top level of the one-wire RTC/NVRAM device: command sequencer around an NVRAM
// memory and a scratchpad memory, with a 40-bit clock register.
// Depends on owrtc_pkg.
//
// channel | dir | handshake             | payload
// --------+-----+-----------------------+--------------------------------------
// s       | in  | i_s_tvalid/o_s_tready | tuser: command; tdata: write_byte
// m       | out | o_m_tvalid/i_m_tready | tdata: read_byte; tuser: error
//
// One result per request. A data read in the read-memory phase passes through
// S_READ, which takes the registered NVRAM read port output. A copy walks the
// scratchpad through its read port and holds off the input in S_COPY until
// min(count,32) bytes have been copied.
// After reset a clearing pass zeroes the NVRAM and the scratchpad before the
// first request is taken. A result waiting in the output register stalls only the
// next request.
`default_nettype none
module one_wire_rtc_nvram_device #(
    parameter int NVRAM_BYTES   = owrtc_pkg::NVRAM_BYTES_DEF,
    parameter int SCRATCH_BYTES = owrtc_pkg::SCRATCH_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] write_byte
    input  wire logic [2:0] i_s_tuser,   // [2:0] command
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] read_byte
    output logic [0:0]      o_m_tuser    // [0] error
);

    localparam int NA = $clog2(NVRAM_BYTES);
    localparam int SA = $clog2(SCRATCH_BYTES);
    localparam int CW = SA + 1;

    owrtc_pkg::t_state r_state, n_state;
    owrtc_pkg::t_phase r_phase, n_phase;
    owrtc_pkg::t_op    r_op, n_op;
    owrtc_pkg::t_cmd   cmd;

    logic [7:0]    r_addr_lo, n_addr_lo;
    logic [7:0]    r_addr_hi, n_addr_hi;
    logic [15:0]   r_mem_ptr, n_mem_ptr;
    logic [CW-1:0] r_sp_ptr, n_sp_ptr;
    logic [39:0]   r_clock, n_clock;
    logic [NA-1:0] r_clr, n_clr;
    logic [CW-1:0] r_cp_idx, n_cp_idx;
    logic [CW-1:0] r_cp_n, n_cp_n;
    logic [15:0]   r_cp_addr, n_cp_addr;
    logic [15:0]   r_wr_addr, n_wr_addr;
    logic          r_wr_pend, n_wr_pend;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_data, n_out_data;
    logic          r_out_err, n_out_err;

    logic [7:0]    r_nvram [NVRAM_BYTES];
    logic [7:0]    r_scratch [SCRATCH_BYTES];
    logic [7:0]    r_nv_rdata;
    logic [7:0]    r_sp_rdata;

    logic          nv_we;
    logic [NA-1:0] nv_wa;
    logic [7:0]    nv_wd;
    logic [NA-1:0] nv_ra;
    logic          sp_we;
    logic [SA-1:0] sp_wa;
    logic [7:0]    sp_wd;
    logic [SA-1:0] sp_ra;

    logic          accept;
    logic [15:0]   addr_full;
    logic [15:0]   rd_off;
    logic [2:0]    rd_slot;
    logic [15:0]   wr_off;
    logic [7:0]    clk_byte;

    assign cmd        = owrtc_pkg::t_cmd'(i_s_tuser);
    assign o_s_tready = (r_state == owrtc_pkg::S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_err;
    assign addr_full  = {i_s_tdata, r_addr_lo};

    assign rd_off   = r_mem_ptr - owrtc_pkg::CLK_FIRST;
    assign rd_slot  = (rd_off[2:0] == owrtc_pkg::CLK_TOP_SLOT) ? 3'd0 : rd_off[2:0] + 3'd1;
    assign clk_byte = r_clock[{rd_slot, 3'b000} +: 8];
    assign wr_off   = r_wr_addr - owrtc_pkg::CLK_FIRST;

    always_ff @(posedge i_clk) begin
        if (nv_we) begin
            r_nvram[nv_wa] <= nv_wd;
        end
        r_nv_rdata <= r_nvram[nv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sp_we) begin
            r_scratch[sp_wa] <= sp_wd;
        end
        r_sp_rdata <= r_scratch[sp_ra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            owrtc_pkg::S_CLEAR: begin
                if (r_clr == NA'(NVRAM_BYTES - 1)) begin
                    n_state = owrtc_pkg::S_IDLE;
                end
            end
            owrtc_pkg::S_IDLE: begin
                if (accept && cmd == owrtc_pkg::CMD_WRITE
                        && r_phase == owrtc_pkg::PH_COUNT) begin
                    n_state = owrtc_pkg::S_COPY;
                end else if (accept && cmd == owrtc_pkg::CMD_READ
                        && r_phase == owrtc_pkg::PH_READ_MEM) begin
                    n_state = owrtc_pkg::S_READ;
                end
            end
            owrtc_pkg::S_READ: begin
                n_state = owrtc_pkg::S_IDLE;
            end
            owrtc_pkg::S_COPY: begin
                if (r_cp_idx == r_cp_n && !r_wr_pend) begin
                    n_state = owrtc_pkg::S_IDLE;
                end
            end
            default: n_state = owrtc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_op        = r_op;
        n_addr_lo   = r_addr_lo;
        n_addr_hi   = r_addr_hi;
        n_mem_ptr   = r_mem_ptr;
        n_sp_ptr    = r_sp_ptr;
        n_clock     = r_clock;
        n_clr       = r_clr;
        n_cp_idx    = r_cp_idx;
        n_cp_n      = r_cp_n;
        n_cp_addr   = r_cp_addr;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_err   = r_out_err;
        nv_we       = 1'b0;
        nv_wa       = r_wr_addr[NA-1:0];
        nv_wd       = r_sp_rdata;
        nv_ra       = r_mem_ptr[NA-1:0];
        sp_we       = 1'b0;
        sp_wa       = r_sp_ptr[SA-1:0];
        sp_wd       = i_s_tdata;
        sp_ra       = r_cp_idx[SA-1:0];

        unique case (r_state)
            owrtc_pkg::S_CLEAR: begin
                nv_we = 1'b1;
                nv_wa = r_clr;
                nv_wd = 8'h00;
                sp_we = 1'b1;
                sp_wa = r_clr[SA-1:0];
                sp_wd = 8'h00;
                n_clr = r_clr + NA'(1);
            end
            owrtc_pkg::S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out_data  = 8'h00;
                    n_out_err   = 1'b0;
                    unique case (cmd)
                        owrtc_pkg::CMD_WRITE: begin
                            unique case (r_phase)
                                owrtc_pkg::PH_ROM: begin
                                    if (i_s_tdata == owrtc_pkg::ROM_SKIP) begin
                                        n_phase = owrtc_pkg::PH_CMD;
                                    end else begin
                                        n_out_err = 1'b1;
                                    end
                                end
                                owrtc_pkg::PH_CMD: begin
                                    n_phase = owrtc_pkg::PH_ADDR_LO;
                                    if (i_s_tdata == owrtc_pkg::MEM_WRITE_SP) begin
                                        n_op = owrtc_pkg::OP_WRITE_SP;
                                    end else if (i_s_tdata == owrtc_pkg::MEM_COPY_SP) begin
                                        n_op = owrtc_pkg::OP_COPY;
                                    end else if (i_s_tdata == owrtc_pkg::MEM_READ) begin
                                        n_op = owrtc_pkg::OP_READ_MEM;
                                    end else begin
                                        n_phase   = r_phase;
                                        n_out_err = 1'b1;
                                    end
                                end
                                owrtc_pkg::PH_ADDR_LO: begin
                                    n_addr_lo = i_s_tdata;
                                    n_phase   = owrtc_pkg::PH_ADDR_HI;
                                end
                                owrtc_pkg::PH_ADDR_HI: begin
                                    n_addr_hi = i_s_tdata;
                                    unique case (r_op)
                                        owrtc_pkg::OP_COPY: begin
                                            n_phase = owrtc_pkg::PH_COUNT;
                                        end
                                        owrtc_pkg::OP_READ_MEM: begin
                                            n_mem_ptr = addr_full - 16'd2;
                                            n_phase   = owrtc_pkg::PH_READ_MEM;
                                        end
                                        default: begin
                                            n_sp_ptr = {1'b0, addr_full[SA-1:0]};
                                            n_phase  = owrtc_pkg::PH_WRITE_SP;
                                        end
                                    endcase
                                end
                                owrtc_pkg::PH_COUNT: begin
                                    n_cp_n    = (i_s_tdata > 8'(SCRATCH_BYTES))
                                                ? CW'(SCRATCH_BYTES) : i_s_tdata[CW-1:0];
                                    n_cp_idx  = '0;
                                    n_cp_addr = {r_addr_hi, r_addr_lo};
                                    n_phase   = owrtc_pkg::PH_COPY_DONE;
                                end
                                owrtc_pkg::PH_WRITE_SP: begin
                                    if (r_sp_ptr < CW'(SCRATCH_BYTES)) begin
                                        sp_we    = 1'b1;
                                        n_sp_ptr = r_sp_ptr + CW'(1);
                                    end
                                end
                                default: ;
                            endcase
                        end
                        owrtc_pkg::CMD_READ: begin
                            if (r_phase == owrtc_pkg::PH_READ_MEM) begin
                                n_out_valid = 1'b0;
                            end
                        end
                        owrtc_pkg::CMD_PULSE: begin
                            if (r_phase == owrtc_pkg::PH_READ_MEM) begin
                                n_mem_ptr = r_mem_ptr + 16'd1;
                            end
                        end
                        owrtc_pkg::CMD_RST1W: n_phase = owrtc_pkg::PH_ROM;
                        owrtc_pkg::CMD_RST3W: n_phase = owrtc_pkg::PH_CMD;
                        default: ;
                    endcase
                end
            end
            owrtc_pkg::S_READ: begin
                n_out_valid = 1'b1;
                n_out_err   = 1'b0;
                if (r_mem_ptr < 16'(NVRAM_BYTES)) begin
                    n_out_data = r_nv_rdata;
                end else if (r_mem_ptr >= owrtc_pkg::CLK_FIRST
                        && r_mem_ptr <= owrtc_pkg::CLK_LAST) begin
                    n_out_data = clk_byte;
                end else begin
                    n_out_data = 8'h00;
                end
            end
            owrtc_pkg::S_COPY: begin
                if (r_wr_pend) begin
                    if (r_wr_addr < 16'(NVRAM_BYTES)) begin
                        nv_we = 1'b1;
                    end else if (r_wr_addr >= owrtc_pkg::CLK_FIRST
                            && r_wr_addr <= owrtc_pkg::CLK_LAST) begin
                        n_clock[{wr_off[2:0], 3'b000} +: 8] = r_sp_rdata;
                    end
                end
                if (r_cp_idx != r_cp_n) begin
                    n_cp_idx  = r_cp_idx + CW'(1);
                    n_cp_addr = r_cp_addr + 16'd1;
                    n_wr_addr = r_cp_addr;
                    n_wr_pend = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= owrtc_pkg::S_CLEAR;
            r_phase     <= owrtc_pkg::PH_INACTIVE;
            r_op        <= owrtc_pkg::OP_WRITE_SP;
            r_addr_lo   <= '0;
            r_addr_hi   <= '0;
            r_mem_ptr   <= '0;
            r_sp_ptr    <= '0;
            r_clock     <= '0;
            r_clr       <= '0;
            r_cp_idx    <= '0;
            r_cp_n      <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_op        <= n_op;
            r_addr_lo   <= n_addr_lo;
            r_addr_hi   <= n_addr_hi;
            r_mem_ptr   <= n_mem_ptr;
            r_sp_ptr    <= n_sp_ptr;
            r_clock     <= n_clock;
            r_clr       <= n_clr;
            r_cp_idx    <= n_cp_idx;
            r_cp_n      <= n_cp_n;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr  <= n_cp_addr;
        r_wr_addr  <= n_wr_addr;
        r_out_data <= n_out_data;
        r_out_err  <= n_out_err;
    end

endmodule
`default_nettype wire
